@@ src/dwr_pkg.sv @@
// shared types, constants and ring helpers for the deque with reverse
package dwr_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 72;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_PEEK       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_PUSH,
    K_POP,
    K_REVERSE,
    K_PEEK,
    K_NONE
  } kind_t;

  typedef enum logic [1:0] {
    B_EXEC,
    B_READ,
    B_RESP
  } back_state_t;

  typedef struct packed {
    kind_t  kind;
    logic   at_front;
    value_t value;
  } cmd_t;

  typedef struct packed {
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
    logic [WORD_W-1:0]   back_value;
    logic [WORD_W-1:0]   front_value;
    status_t             status;
  } res_t;

  function automatic ptr_t ring_add(ptr_t base, ptr_t off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (PTR_W + 1)'(CAPACITY)) s = s - (PTR_W + 1)'(CAPACITY);
    return s[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_dec(ptr_t base);
    ptr_t r;
    if (base == '0) r = PTR_W'(CAPACITY - 1);
    else r = base - 1'b1;
    return r;
  endfunction

endpackage

@@ src/dwr_cmd_queue.sv @@
// two-entry command queue between the front and back parts
module dwr_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dwr_pkg::cmd_t   in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output dwr_pkg::cmd_t   out_cmd
);

  dwr_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_wr;
  logic          do_rd;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_cmd   = slots[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      if (do_wr && !do_rd) fill <= fill + 2'd1;
      else if (do_rd && !do_wr) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= in_cmd;
  end

endmodule

@@ src/dwr_front.sv @@
// front part: takes input words, classifies the operation, queues commands
module dwr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          operation,
  input  logic [31:0]         push_value,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output dwr_pkg::cmd_t       cmd
);

  dwr_pkg::cmd_t dec;

  always_comb begin
    dec.value    = dwr_pkg::VALUE_BITS'(push_value);
    dec.at_front = 1'b0;
    dec.kind     = dwr_pkg::K_NONE;
    case (operation)
      dwr_pkg::OP_PUSH_FRONT: begin
        dec.kind     = dwr_pkg::K_PUSH;
        dec.at_front = 1'b1;
      end
      dwr_pkg::OP_PUSH_BACK: begin
        dec.kind = dwr_pkg::K_PUSH;
      end
      dwr_pkg::OP_POP_FRONT: begin
        dec.kind     = dwr_pkg::K_POP;
        dec.at_front = 1'b1;
      end
      dwr_pkg::OP_POP_BACK: begin
        dec.kind = dwr_pkg::K_POP;
      end
      dwr_pkg::OP_REVERSE: begin
        dec.kind = dwr_pkg::K_REVERSE;
      end
      dwr_pkg::OP_PEEK: begin
        dec.kind = dwr_pkg::K_PEEK;
      end
      default: begin
        dec.kind = dwr_pkg::K_NONE;
      end
    endcase
  end

  dwr_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (dec),
    .out_valid (cmd_valid),
    .out_ready (cmd_ready),
    .out_cmd   (cmd)
  );

endmodule

@@ src/dwr_back.sv @@
// back part: ring store, pointer update, end reads and result register
module dwr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  dwr_pkg::cmd_t   cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output dwr_pkg::res_t   res
);

  dwr_pkg::value_t      store [dwr_pkg::CAPACITY];
  dwr_pkg::back_state_t state;
  dwr_pkg::back_state_t state_next;
  dwr_pkg::ptr_t        head;
  dwr_pkg::ptr_t        head_next;
  dwr_pkg::cnt_t        count;
  dwr_pkg::cnt_t        count_next;
  logic                 rev;
  logic                 rev_next;
  dwr_pkg::status_t     status;
  dwr_pkg::status_t     status_next;
  logic                 wr_en;
  dwr_pkg::ptr_t        wr_addr;
  dwr_pkg::value_t      rd_lo;
  dwr_pkg::value_t      rd_hi;
  dwr_pkg::ptr_t        hi_off;
  dwr_pkg::ptr_t        hi_addr;
  logic                 is_empty;
  logic                 is_full;
  logic                 at_low;
  logic                 load_out;
  logic [dwr_pkg::WORD_W-1:0] lo_word;
  logic [dwr_pkg::WORD_W-1:0] hi_word;

  assign is_empty = (count == '0);
  assign is_full  = (count == dwr_pkg::CNT_W'(dwr_pkg::CAPACITY));
  assign at_low   = cmd.at_front ^ rev;
  assign hi_off   = is_empty ? '0 : dwr_pkg::PTR_W'(count - 1'b1);
  assign hi_addr  = dwr_pkg::ring_add(head, hi_off);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dwr_pkg::B_EXEC: if (cmd_valid) state_next = dwr_pkg::B_READ;
      dwr_pkg::B_READ: state_next = dwr_pkg::B_RESP;
      dwr_pkg::B_RESP: if (!res_valid || res_ready) state_next = dwr_pkg::B_EXEC;
      default:         state_next = dwr_pkg::B_EXEC;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready = (state == dwr_pkg::B_EXEC);
    load_out  = (state == dwr_pkg::B_RESP) && (!res_valid || res_ready);
  end

  // operation on the ring
  always_comb begin
    head_next   = head;
    count_next  = count;
    rev_next    = rev;
    status_next = status;
    wr_en       = 1'b0;
    wr_addr     = dwr_pkg::ring_add(head, dwr_pkg::PTR_W'(count));
    if (state == dwr_pkg::B_EXEC && cmd_valid) begin
      status_next = dwr_pkg::ST_DONE;
      case (cmd.kind)
        dwr_pkg::K_PUSH: begin
          if (is_full) begin
            status_next = dwr_pkg::ST_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
            if (at_low) begin
              head_next = dwr_pkg::ring_dec(head);
              wr_addr   = dwr_pkg::ring_dec(head);
            end
          end
        end
        dwr_pkg::K_POP: begin
          if (is_empty) begin
            status_next = dwr_pkg::ST_EMPTY;
          end else begin
            count_next = count - 1'b1;
            if (at_low) head_next = dwr_pkg::ring_add(head, dwr_pkg::PTR_W'(1));
          end
        end
        dwr_pkg::K_REVERSE: begin
          if (is_empty) status_next = dwr_pkg::ST_EMPTY;
          else rev_next = ~rev;
        end
        dwr_pkg::K_PEEK: begin
          if (is_empty) status_next = dwr_pkg::ST_EMPTY;
        end
        default: begin
          status_next = dwr_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwr_pkg::B_EXEC;
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= cmd.value;
    if (state == dwr_pkg::B_READ) begin
      rd_lo <= store[head];
      rd_hi <= store[hi_addr];
    end
  end

  assign lo_word = is_empty ? '0 : dwr_pkg::WORD_W'(rd_lo);
  assign hi_word = is_empty ? '0 : dwr_pkg::WORD_W'(rd_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.status      <= status;
      res.front_value <= rev ? hi_word : lo_word;
      res.back_value  <= rev ? lo_word : hi_word;
      res.entry_count <= dwr_pkg::COUNT_W'(count);
      res.is_empty    <= is_empty;
    end
  end

endmodule

@@ src/deque_with_reverse.sv @@
// top level of the deque with reverse
// the back part takes one command at a time through its execute, store read and
//   result load states; a 2-entry command queue lets the input run ahead
// reset clears head, count, direction flag, command queue and result valid flag;
//   the ring store and result data are not cleared
module deque_with_reverse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // operation[2:0], push_value[34:3], zero[39:35]
  input  logic [dwr_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], front_value[33:2], back_value[65:34], entry_count[70:66], is_empty[71]
  output logic [dwr_pkg::OUT_W-1:0]   m_axis_tdata
);

  logic          cmd_valid;
  logic          cmd_ready;
  dwr_pkg::cmd_t cmd;
  dwr_pkg::res_t res;

  dwr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .operation  (s_axis_tdata[2:0]),
    .push_value (s_axis_tdata[34:3]),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  dwr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = res;

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.is_empty |->
      res.front_value == '0 && res.back_value == '0 && res.entry_count == '0)
    else $error("empty result carries values");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res.entry_count <= dwr_pkg::COUNT_W'(dwr_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status == dwr_pkg::ST_FULL |->
      res.entry_count == dwr_pkg::COUNT_W'(dwr_pkg::CAPACITY))
    else $error("full status without a full queue");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status == dwr_pkg::ST_EMPTY |-> res.is_empty)
    else $error("empty status on a non-empty queue");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the deque with reverse: ring predictor, scoreboard, stream drivers
`timescale 1ns / 1ps

module tb_top;
  import dwr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 90;
  localparam int RANDOM_WORDS = 1250;
  localparam int QUIET_FROM   = 1100;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam value_t ALL_ONES = '1;

  class deque_scoreboard;
    value_t ring [CAPACITY];
    int head;
    int held;
    bit flipped;
    res_t waiting [$];
    int errors;
    int n_push, n_pop, n_rev, n_peek, n_spare, n_full, n_empty, deepest;

    function int pending();
      return waiting.size();
    endfunction

    // advance the ring copy by one accepted word and queue the result it causes
    function void note_word(logic [2:0] op, value_t v);
      res_t r;
      bit front_low;
      value_t lo_v, hi_v;
      r = '0;
      r.status = ST_DONE;
      front_low = !flipped;
      lo_v = '0;
      hi_v = '0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          n_push++;
          if (held == CAPACITY) begin
            r.status = ST_FULL;
            n_full++;
          end else if ((op == OP_PUSH_FRONT) == front_low) begin
            head = (head + CAPACITY - 1) % CAPACITY;
            ring[head] = v;
            held++;
          end else begin
            ring[(head + held) % CAPACITY] = v;
            held++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          n_pop++;
          if (held == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            if ((op == OP_POP_FRONT) == front_low) head = (head + 1) % CAPACITY;
            held--;
          end
        end
        OP_REVERSE: begin
          n_rev++;
          if (held == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            flipped = !flipped;
          end
        end
        OP_PEEK: begin
          n_peek++;
          if (held == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end
        end
        default: n_spare++;
      endcase
      if (held != 0) begin
        lo_v = ring[head];
        hi_v = ring[(head + held - 1) % CAPACITY];
      end
      r.front_value = flipped ? hi_v : lo_v;
      r.back_value  = flipped ? lo_v : hi_v;
      r.entry_count = held[COUNT_W-1:0];
      r.is_empty    = (held == 0);
      if (held > deepest) deepest = held;
      waiting.push_back(r);
    endfunction

    task report(string what, logic [71:0] got, logic [71:0] want);
      if (errors < 40) $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_word(res_t got);
      res_t want;
      if (waiting.size() == 0) begin
        report("unexpected word", got, '0);
      end else begin
        want = waiting.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.front_value !== want.front_value)
          report("front value", got.front_value, want.front_value);
        if (got.back_value !== want.back_value)
          report("back value", got.back_value, want.back_value);
        if (got.entry_count !== want.entry_count)
          report("entry count", got.entry_count, want.entry_count);
        if (got.is_empty !== want.is_empty) report("empty flag", got.is_empty, want.is_empty);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  deque_scoreboard sb = new();
  bit hold_req = 0;
  bit quiet = 0;
  int gap_pct = 0;
  int holds_done = 0;
  int cycle_count = 0;

  deque_with_reverse dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_word(s_axis_tdata[2:0], s_axis_tdata[34:3]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata);
  end

  // receiver: random stall bursts, one long hold on request, none once quiet
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
        holds_done++;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [2:0] op, input value_t v);
    if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, v, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic value_t rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ALL_ONES;
      2: return value_t'(1) << $urandom_range(0, VALUE_BITS - 1);
      3: return value_t'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // mode 0 leans to pushes, 1 to pops, 2 is balanced, 3 is any code at all
  function automatic logic [2:0] pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 3) return 3'($urandom_range(0, 7));
    case (mode)
      0: begin
        if (r < 35) return OP_PUSH_FRONT;
        if (r < 70) return OP_PUSH_BACK;
        if (r < 78) return OP_POP_FRONT;
        if (r < 86) return OP_POP_BACK;
        if (r < 93) return OP_REVERSE;
        return OP_PEEK;
      end
      1: begin
        if (r < 10) return OP_PUSH_FRONT;
        if (r < 20) return OP_PUSH_BACK;
        if (r < 50) return OP_POP_FRONT;
        if (r < 80) return OP_POP_BACK;
        if (r < 90) return OP_REVERSE;
        return OP_PEEK;
      end
      default: begin
        if (r < 25) return OP_PUSH_FRONT;
        if (r < 50) return OP_PUSH_BACK;
        if (r < 65) return OP_POP_FRONT;
        if (r < 80) return OP_POP_BACK;
        if (r < 92) return OP_REVERSE;
        return OP_PEEK;
      end
    endcase
  endfunction

  task automatic run_directed();
    send_word(OP_PEEK, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_REVERSE, '0);
    send_word(OP_SPARE_A, ALL_ONES);
    send_word(OP_SPARE_B, ALL_ONES);
    send_word(OP_PUSH_BACK, ALL_ONES);
    send_word(OP_REVERSE, '0);
    send_word(OP_PEEK, '0);
    send_word(OP_POP_FRONT, '0);
    for (int i = 0; i < CAPACITY; i++)
      send_word(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                (i[1] ? 32'hAAAA_AAAA : 32'h5555_5555) ^ value_t'(i));
    send_word(OP_PUSH_FRONT, ALL_ONES);
    send_word(OP_PUSH_BACK, '0);
    send_word(OP_REVERSE, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);
  endtask

  task automatic run_random();
    int done_words;
    int seg_len;
    int mode;
    logic [2:0] op;
    bit paused;
    done_words = 0;
    paused = 0;

    // long receiver hold with the sender pushing on, so the block backs up
    gap_pct = 0;
    hold_req = 1;
    for (int i = 0; i < 12 || hold_req; i++) begin
      op = pick_op(0);
      send_word(op, rand_value());
      if (op < OP_SPARE_A) done_words++;
    end

    while (done_words < RANDOM_WORDS) begin
      if (done_words >= QUIET_FROM) quiet = 1;
      if (!paused && done_words >= RANDOM_WORDS / 2) begin
        wait_drained();
        paused = 1;
      end
      mode = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      seg_len = $urandom_range(10, 40);
      for (int i = 0; i < seg_len; i++) begin
        op = pick_op(mode);
        send_word(op, rand_value());
        if (op < OP_SPARE_A) done_words++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("ran %0d pushes, %0d pops, %0d reverses, %0d peeks, %0d unused codes",
             sb.n_push, sb.n_pop, sb.n_rev, sb.n_peek, sb.n_spare);
    $display("refused %0d on empty and %0d on full, deepest fill %0d, long holds %0d",
             sb.n_empty, sb.n_full, sb.deepest, holds_done);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d words still expected", sb.errors, sb.pending());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
